### rtl/svps_pkg.sv
// Shared types and constants for the stochastic volatility path step unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package svps_pkg;

  localparam int DataWidth = 32;
  localparam int FracBits  = 24;

  // Radicand of the root: nonnegative variance shifted up by the fraction bits.
  localparam int RadBits  = DataWidth - 1 + FracBits;
  localparam int SqrtBits = (RadBits + 1) / 2;

  localparam int CfgIndexBits = 3;

  localparam logic [CfgIndexBits-1:0] RegDriftDt          = 3'd0;
  localparam logic [CfgIndexBits-1:0] RegHalfDt           = 3'd1;
  localparam logic [CfgIndexBits-1:0] RegReversionDt      = 3'd2;
  localparam logic [CfgIndexBits-1:0] RegReversionLevelDt = 3'd3;
  localparam logic [CfgIndexBits-1:0] RegRootDt           = 3'd4;
  localparam logic [CfgIndexBits-1:0] RegVolvolRho        = 3'd5;
  localparam logic [CfgIndexBits-1:0] RegVolvolRhoComp    = 3'd6;
  localparam logic [CfgIndexBits-1:0] RegInitialVariance  = 3'd7;

  typedef enum logic [1:0] {
    AluMul,  // load magnitude product register
    AluFin,  // scale, saturate and sign the held product
    AluAdd,  // saturating a + b
    AluSub   // saturating a - b
  } alu_op_e;

  typedef struct packed {
    logic    en;
    alu_op_e op;
  } alu_req_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] normal_price;
    logic signed [DataWidth-1:0] normal_indep;
    logic                        path_start;
    logic                        last_step;
  } svps_in_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] log_offset;
    logic signed [DataWidth-1:0] variance_out;
    logic                        path_end;
  } svps_out_t;

endpackage

`default_nettype wire

### rtl/stochastic_volatility_path_step_unit.sv
// Heston full-truncation Euler step, one path step per request.
// Each request runs one load, 28 root iterations and 21 shared-unit steps;
// the last step waits while a stalled result is still held. A new request
// is taken from the cycle the result turns valid, not before: the bit-serial
// root and the single multiplier/adder serve all seven products and seven sums.
// Reset (async, active low) clears configuration, path state and valids.
`default_nettype none

module stochastic_volatility_path_step_unit import svps_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire svps_in_t                in_data_i,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output svps_out_t                    out_data_o,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [CfgIndexBits-1:0] cfg_index_i,
  input  wire logic [DataWidth-1:0]    cfg_data_i
);

  localparam int W = DataWidth;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StSqrt = 2'd1;
  localparam logic [1:0] StCalc = 2'd2;

  localparam logic [4:0] StepHalfMul   = 5'd0;
  localparam logic [4:0] StepHalfFin   = 5'd1;
  localparam logic [4:0] StepDriftSub  = 5'd2;
  localparam logic [4:0] StepSrMul     = 5'd3;
  localparam logic [4:0] StepSrFin     = 5'd4;
  localparam logic [4:0] StepZ1Mul     = 5'd5;
  localparam logic [4:0] StepZ1Fin     = 5'd6;
  localparam logic [4:0] StepLogInc    = 5'd7;
  localparam logic [4:0] StepLogAdd    = 5'd8;
  localparam logic [4:0] StepRhoMul    = 5'd9;
  localparam logic [4:0] StepRhoFin    = 5'd10;
  localparam logic [4:0] StepCompMul   = 5'd11;
  localparam logic [4:0] StepCompFin   = 5'd12;
  localparam logic [4:0] StepZSum      = 5'd13;
  localparam logic [4:0] StepRevMul    = 5'd14;
  localparam logic [4:0] StepRevFin    = 5'd15;
  localparam logic [4:0] StepLevelSub  = 5'd16;
  localparam logic [4:0] StepSzMul     = 5'd17;
  localparam logic [4:0] StepSzFin     = 5'd18;
  localparam logic [4:0] StepVarInc    = 5'd19;
  localparam logic [4:0] StepVarAdd    = 5'd20;

  localparam logic [2:0] DstNone = 3'd0;
  localparam logic [2:0] DstTmp  = 3'd1;
  localparam logic [2:0] DstAcc1 = 3'd2;
  localparam logic [2:0] DstAcc2 = 3'd3;
  localparam logic [2:0] DstZ    = 3'd4;
  localparam logic [2:0] DstLog  = 3'd5;
  localparam logic [2:0] DstVar  = 3'd6;

  // configuration
  logic signed [W-1:0] drift_dt_q, volvol_rho_q;
  logic [W-2:0] half_dt_q, reversion_dt_q, reversion_level_dt_q;
  logic [W-2:0] root_dt_q, volvol_rho_comp_q, initial_variance_q;

  // path state and step temporaries
  logic signed [W-1:0] var_q, log_q;
  logic signed [W-1:0] vp_q, tmp_q, acc1_q, acc2_q, zt_q;
  logic signed [W-1:0] z1_q, eps_q;
  logic                last_q;

  logic [1:0] state_q;
  logic [4:0] step_q;
  logic       out_valid_q;
  svps_out_t  out_data_q;

  logic in_accept, out_free, step_go;
  logic [W-2:0] vp_d;
  logic sq_busy;
  logic [SqrtBits-1:0] sq_root;
  logic signed [W-1:0] s_val;

  alu_req_t alu_req;
  logic signed [W-1:0] alu_a, alu_b, alu_res;
  logic [2:0] dst;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != StIdle);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign step_go     = (state_q == StCalc) && ((step_q != StepVarAdd) || out_free);

  // truncated variance of the (possibly freshly loaded) state
  assign vp_d = in_data_i.path_start ? initial_variance_q
              : (var_q[W-1] ? '0 : var_q[W-2:0]);

  svps_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_accept),
    .value_i (vp_d),
    .busy_o  (sq_busy),
    .root_o  (sq_root)
  );

  assign s_val = {{(W-SqrtBits){1'b0}}, sq_root};

  always_comb begin
    alu_req.en = step_go;
    alu_req.op = AluMul;
    alu_a      = '0;
    alu_b      = '0;
    dst        = DstNone;
    case (step_q)
      StepHalfMul: begin
        alu_a = {1'b0, half_dt_q}; alu_b = vp_q;
      end
      StepHalfFin: begin
        alu_req.op = AluFin; dst = DstTmp;
      end
      StepDriftSub: begin
        alu_req.op = AluSub; alu_a = drift_dt_q; alu_b = tmp_q; dst = DstAcc1;
      end
      StepSrMul: begin
        alu_a = s_val; alu_b = {1'b0, root_dt_q};
      end
      StepSrFin: begin
        alu_req.op = AluFin; dst = DstTmp;
      end
      StepZ1Mul: begin
        alu_a = tmp_q; alu_b = z1_q;
      end
      StepZ1Fin: begin
        alu_req.op = AluFin; dst = DstTmp;
      end
      StepLogInc: begin
        alu_req.op = AluAdd; alu_a = acc1_q; alu_b = tmp_q; dst = DstAcc1;
      end
      StepLogAdd: begin
        alu_req.op = AluAdd; alu_a = log_q; alu_b = acc1_q; dst = DstLog;
      end
      StepRhoMul: begin
        alu_a = volvol_rho_q; alu_b = z1_q;
      end
      StepRhoFin: begin
        alu_req.op = AluFin; dst = DstTmp;
      end
      StepCompMul: begin
        alu_a = {1'b0, volvol_rho_comp_q}; alu_b = eps_q;
      end
      StepCompFin: begin
        alu_req.op = AluFin; dst = DstZ;
      end
      StepZSum: begin
        alu_req.op = AluAdd; alu_a = tmp_q; alu_b = zt_q; dst = DstZ;
      end
      StepRevMul: begin
        alu_a = {1'b0, reversion_dt_q}; alu_b = vp_q;
      end
      StepRevFin: begin
        alu_req.op = AluFin; dst = DstTmp;
      end
      StepLevelSub: begin
        alu_req.op = AluSub; alu_a = {1'b0, reversion_level_dt_q}; alu_b = tmp_q;
        dst = DstAcc2;
      end
      StepSzMul: begin
        alu_a = s_val; alu_b = zt_q;
      end
      StepSzFin: begin
        alu_req.op = AluFin; dst = DstTmp;
      end
      StepVarInc: begin
        alu_req.op = AluAdd; alu_a = acc2_q; alu_b = tmp_q; dst = DstAcc2;
      end
      StepVarAdd: begin
        alu_req.op = AluAdd; alu_a = var_q; alu_b = acc2_q; dst = DstVar;
      end
      default: begin
        alu_req.en = 1'b0;
      end
    endcase
  end

  svps_alu u_alu (
    .clk_i (clk_i),
    .req_i (alu_req),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drift_dt_q           <= '0;
      half_dt_q            <= '0;
      reversion_dt_q       <= '0;
      reversion_level_dt_q <= '0;
      root_dt_q            <= '0;
      volvol_rho_q         <= '0;
      volvol_rho_comp_q    <= '0;
      initial_variance_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegDriftDt:          drift_dt_q           <= cfg_data_i;
        RegHalfDt:           half_dt_q            <= cfg_data_i[W-2:0];
        RegReversionDt:      reversion_dt_q       <= cfg_data_i[W-2:0];
        RegReversionLevelDt: reversion_level_dt_q <= cfg_data_i[W-2:0];
        RegRootDt:           root_dt_q            <= cfg_data_i[W-2:0];
        RegVolvolRho:        volvol_rho_q         <= cfg_data_i;
        RegVolvolRhoComp:    volvol_rho_comp_q    <= cfg_data_i[W-2:0];
        RegInitialVariance:  initial_variance_q   <= cfg_data_i[W-2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= '0;
      var_q       <= '0;
      log_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (step_go && step_q == StepVarAdd) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_accept) begin
            state_q <= StSqrt;
            if (in_data_i.path_start) begin
              var_q <= {1'b0, initial_variance_q};
              log_q <= '0;
            end
          end
        end
        StSqrt: begin
          if (!sq_busy) begin
            state_q <= StCalc;
            step_q  <= StepHalfMul;
          end
        end
        StCalc: begin
          if (step_go) begin
            if (dst == DstLog) log_q <= alu_res;
            if (dst == DstVar) var_q <= alu_res;
            if (step_q == StepVarAdd) begin
              state_q <= StIdle;
            end else begin
              step_q <= step_q + 1'b1;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      vp_q   <= {1'b0, vp_d};
      z1_q   <= in_data_i.normal_price;
      eps_q  <= in_data_i.normal_indep;
      last_q <= in_data_i.last_step;
    end
    if (step_go) begin
      case (dst)
        DstTmp:  tmp_q  <= alu_res;
        DstAcc1: acc1_q <= alu_res;
        DstAcc2: acc2_q <= alu_res;
        DstZ:    zt_q   <= alu_res;
        default: ;
      endcase
      if (step_q == StepVarAdd) begin
        out_data_q.log_offset   <= log_q;
        out_data_q.variance_out <= alu_res;
        out_data_q.path_end     <= last_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

### rtl/svps_sqrt.sv
// Bit-serial restoring square root, one result bit per cycle.
// Depends on svps_pkg for widths.
`default_nettype none

module svps_sqrt import svps_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [DataWidth-2:0]   value_i,
  output logic                        busy_o,
  output logic [SqrtBits-1:0]         root_o
);

  localparam int CntBits = $clog2(SqrtBits + 1);
  localparam int PadBits = 2 * SqrtBits - RadBits;

  logic [2*SqrtBits-1:0] rad_q;
  logic [SqrtBits+1:0]   rem_q;
  logic [SqrtBits+1:0]   rem_sh;
  logic [SqrtBits+1:0]   trial;
  logic [SqrtBits-1:0]   root_q;
  logic [CntBits-1:0]    cnt_q;
  logic                  busy_q;
  logic                  fits;

  // remainder never exceeds twice the partial root, so its top bits are zero here
  assign rem_sh = {rem_q[SqrtBits-1:0], rad_q[2*SqrtBits-1 -: 2]};
  assign trial  = {root_q, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntBits'(SqrtBits);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= {{PadBits{1'b0}}, value_i, {FracBits{1'b0}}};
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[2*SqrtBits-3:0], 2'b00};
      rem_q  <= fits ? (rem_sh - trial) : rem_sh;
      root_q <= {root_q[SqrtBits-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

### rtl/svps_alu.sv
// Shared fixed-point unit: registered magnitude multiply, then scale and
// saturate; saturating add and subtract. Depends on svps_pkg.
`default_nettype none

module svps_alu import svps_pkg::*; (
  input  wire logic                        clk_i,
  input  wire alu_req_t                    req_i,
  input  wire logic signed [DataWidth-1:0] a_i,
  input  wire logic signed [DataWidth-1:0] b_i,
  output logic signed [DataWidth-1:0]      res_o
);

  localparam int ProdBits  = 2 * DataWidth;
  localparam int ShiftBits = ProdBits - FracBits;

  logic [DataWidth-1:0] ua, ub;
  logic [ProdBits-1:0]  prod_q;
  logic                 neg_q;
  logic [ShiftBits-1:0] shifted;
  logic [DataWidth-1:0] limit;
  logic [DataWidth-1:0] mag;
  logic [DataWidth:0]   sum;
  logic signed [DataWidth-1:0] sat_sum;

  assign ua = a_i[DataWidth-1] ? (~a_i + 1'b1) : a_i;
  assign ub = b_i[DataWidth-1] ? (~b_i + 1'b1) : b_i;

  always_ff @(posedge clk_i) begin
    if (req_i.en && req_i.op == AluMul) begin
      prod_q <= {{DataWidth{1'b0}}, ua} * {{DataWidth{1'b0}}, ub};
      neg_q  <= a_i[DataWidth-1] ^ b_i[DataWidth-1];
    end
  end

  // negative results may reach one step further than positive ones
  assign shifted = prod_q[ProdBits-1:FracBits];
  assign limit   = neg_q ? {1'b1, {(DataWidth-1){1'b0}}} : {1'b0, {(DataWidth-1){1'b1}}};
  assign mag     = (shifted > {{(ShiftBits-DataWidth){1'b0}}, limit}) ? limit
                                                                      : shifted[DataWidth-1:0];

  always_comb begin
    if (req_i.op == AluSub) begin
      sum = {a_i[DataWidth-1], a_i} - {b_i[DataWidth-1], b_i};
    end else begin
      sum = {a_i[DataWidth-1], a_i} + {b_i[DataWidth-1], b_i};
    end
    if (sum[DataWidth] != sum[DataWidth-1]) begin
      sat_sum = sum[DataWidth] ? {1'b1, {(DataWidth-1){1'b0}}}
                               : {1'b0, {(DataWidth-1){1'b1}}};
    end else begin
      sat_sum = sum[DataWidth-1:0];
    end
  end

  always_comb begin
    case (req_i.op)
      AluFin:          res_o = neg_q ? (~mag + 1'b1) : mag;
      AluAdd, AluSub:  res_o = sat_sum;
      default:         res_o = '0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/svps_checker.sv
// Port-level checks for the path step unit, bound to the top level.
// Depends on svps_pkg and stochastic_volatility_path_step_unit.
`default_nettype none

module svps_checker import svps_pkg::*; (
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    in_valid_i,
  input wire logic                    in_stall_o,
  input wire logic                    out_valid_o,
  input wire logic                    out_stall_i,
  input wire svps_out_t               out_data_o,
  input wire logic                    cfg_valid_i,
  input wire logic                    cfg_ready_o
);

  logic in_req;
  assign in_req = in_valid_i && !in_stall_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("stalled result changed");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_req |=> in_stall_o && !$rose(out_valid_o))
    else $error("unit not busy after accepting a request");

  a_free_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o)
    else $error("new result without returning to idle");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind stochastic_volatility_path_step_unit svps_checker u_svps_checker (.*);

`default_nettype wire

### sim/stochastic_volatility_path_step_unit_test.sv
// Self-checking bench for the Heston path step unit: directed table, then random paths.
// Predicts untyped steps in Q format from its own copy of the coefficients and path state.
// Depends on svps_pkg and stochastic_volatility_path_step_unit only.
module stochastic_volatility_path_step_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import svps_pkg::*;

  localparam int HoldCycles    = 400;
  localparam int SettleCycles  = 60;
  localparam int WatchdogLimit = 4000;
  localparam int PhaseItems    = 66;
  localparam int NormSpan      = 5 << FracBits;

  localparam longint QMaxL = (longint'(1) <<< (DataWidth - 1)) - 1;
  localparam longint QMinL = -QMaxL - 1;

  localparam logic signed [DataWidth-1:0] QOne  = 32'sh0100_0000;
  localparam logic signed [DataWidth-1:0] QHalf = 32'sh0080_0000;
  localparam logic signed [DataWidth-1:0] QTwo  = 32'sh0200_0000;
  localparam logic signed [DataWidth-1:0] QMaxW = 32'sh7FFF_FFFF;
  localparam logic signed [DataWidth-1:0] QMinW = 32'sh8000_0000;

  typedef enum logic [2:0] {CfgKeep, CfgCalm, CfgWild, CfgTop, CfgBottom, CfgRandom} cfg_set_e;

  typedef struct packed {
    cfg_set_e                    set;
    logic signed [DataWidth-1:0] z_price;
    logic signed [DataWidth-1:0] z_indep;
    logic                        start;
    logic                        last;
    logic                        typed;
    logic signed [DataWidth-1:0] want_log;
    logic signed [DataWidth-1:0] want_var;
  } step_row_t;

  localparam int NumDirected = 24;
  localparam step_row_t DirectedRows [NumDirected] = '{
    // all coefficients zero: nothing can move
    '{CfgKeep,   0,      0,      1'b0, 1'b0, 1'b1, 0,     0},
    '{CfgKeep,   QMaxW,  QMaxW,  1'b1, 1'b0, 1'b1, 0,     0},
    '{CfgKeep,   QMinW,  QMinW,  1'b0, 1'b1, 1'b1, 0,     0},
    '{CfgKeep,   QMaxW,  QMinW,  1'b1, 1'b1, 1'b1, 0,     0},
    '{CfgCalm,   QOne,   -QOne,  1'b1, 1'b0, 1'b0, 0,     0},
    '{CfgCalm,   0,      0,      1'b0, 1'b0, 1'b0, 0,     0},
    '{CfgCalm,   -QTwo,  QTwo,   1'b0, 1'b0, 1'b0, 0,     0},
    '{CfgCalm,   QMaxW,  QMaxW,  1'b0, 1'b0, 1'b0, 0,     0},
    '{CfgCalm,   QMinW,  QMinW,  1'b0, 1'b1, 1'b0, 0,     0},
    '{CfgCalm,   QHalf,  QHalf,  1'b1, 1'b1, 1'b0, 0,     0},
    // large vol of vol pushes the variance below zero
    '{CfgWild,   -QTwo,  -QTwo,  1'b1, 1'b0, 1'b0, 0,     0},
    '{CfgWild,   -QTwo,  -QTwo,  1'b0, 1'b0, 1'b0, 0,     0},
    '{CfgWild,   QTwo,   -QTwo,  1'b0, 1'b0, 1'b0, 0,     0},
    '{CfgWild,   QOne,   QOne,   1'b0, 1'b1, 1'b0, 0,     0},
    '{CfgTop,    QOne,   QOne,   1'b1, 1'b0, 1'b1, QMaxW, QMaxW},
    '{CfgTop,    QMinW,  QMinW,  1'b0, 1'b0, 1'b0, 0,     0},
    '{CfgTop,    0,      0,      1'b1, 1'b1, 1'b1, 0,     QMaxW},
    '{CfgBottom, QOne,   QOne,   1'b1, 1'b0, 1'b1, QMinW, 0},
    '{CfgBottom, 0,      0,      1'b0, 1'b0, 1'b1, QMinW, 0},
    '{CfgBottom, QMaxW,  QMaxW,  1'b0, 1'b1, 1'b1, QMinW, 0},
    '{CfgRandom, QOne,   QHalf,  1'b1, 1'b0, 1'b0, 0,     0},
    '{CfgRandom, -QHalf, QTwo,   1'b0, 1'b0, 1'b0, 0,     0},
    '{CfgRandom, QMaxW,  QMinW,  1'b0, 1'b0, 1'b0, 0,     0},
    '{CfgRandom, QMinW,  QMaxW,  1'b0, 1'b1, 1'b0, 0,     0}
  };

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  svps_in_t                in_data_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  svps_out_t               out_data_o;
  logic                    cfg_valid_i;
  logic                    cfg_ready_o;
  logic [CfgIndexBits-1:0] cfg_index_i;
  logic [DataWidth-1:0]    cfg_data_i;

  stochastic_volatility_path_step_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Predicted path state and coefficients
  longint    coef [8];
  longint    path_variance;
  longint    path_log_offset;
  svps_out_t expected_points [$];
  int        mismatches;
  int        burst_left;
  int        hold_seq;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint q_add(longint a, longint b);
    longint s;
    s = a + b;
    if (s > QMaxL) return QMaxL;
    if (s < QMinL) return QMinL;
    return s;
  endfunction

  // Magnitude product, truncated toward zero, then signed and clipped.
  function automatic longint q_mul(longint a, longint b);
    logic [127:0] prod;
    longint       ma;
    longint       mb;
    logic         neg;
    neg  = (a < 0) != (b < 0);
    ma   = (a < 0) ? -a : a;
    mb   = (b < 0) ? -b : b;
    prod = (128'(ma) * 128'(mb)) >> FracBits;
    if (neg) begin
      if (prod > 128'(QMaxL) + 1) return QMinL;
      return -longint'(prod[63:0]);
    end
    if (prod > 128'(QMaxL)) return QMaxL;
    return longint'(prod[63:0]);
  endfunction

  function automatic longint q_root(longint v);
    longint rad;
    longint root;
    longint trial;
    rad  = v <<< FracBits;
    root = 0;
    for (int b = SqrtBits - 1; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= rad) root = trial;
    end
    return root;
  endfunction

  function automatic svps_out_t advance_path(svps_in_t req);
    longint    z1;
    longint    eps;
    longint    vp;
    longint    s;
    longint    inc;
    longint    mix;
    svps_out_t pt;
    z1  = longint'($signed(req.normal_price));
    eps = longint'($signed(req.normal_indep));
    if (req.path_start) begin
      path_variance   = coef[RegInitialVariance];
      path_log_offset = 0;
    end
    // both updates use the truncated variance from before the step
    vp  = (path_variance > 0) ? path_variance : 0;
    s   = q_root(vp);
    inc = q_add(coef[RegDriftDt], -q_mul(coef[RegHalfDt], vp));
    inc = q_add(inc, q_mul(q_mul(s, coef[RegRootDt]), z1));
    path_log_offset = q_add(path_log_offset, inc);
    mix = q_add(q_mul(coef[RegVolvolRho], z1), q_mul(coef[RegVolvolRhoComp], eps));
    inc = q_add(coef[RegReversionLevelDt], -q_mul(coef[RegReversionDt], vp));
    inc = q_add(inc, q_mul(s, mix));
    path_variance = q_add(path_variance, inc);
    pt.log_offset   = path_log_offset[DataWidth-1:0];
    pt.variance_out = path_variance[DataWidth-1:0];
    pt.path_end     = req.last_step;
    return pt;
  endfunction

  function automatic logic signed [DataWidth-1:0] draw_normal();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return DataWidth'(int'($urandom_range(0, 2 * NormSpan)) - NormSpan);
    if (pick < 85) return $urandom;
    case ($urandom_range(0, 4))
      0: return QMaxW;
      1: return QMinW;
      2: return 0;
      3: return QOne;
      default: return -QOne;
    endcase
  endfunction

  function automatic svps_in_t make_step(logic start, logic last);
    svps_in_t req;
    req.normal_price = draw_normal();
    req.normal_indep = draw_normal();
    req.path_start   = start;
    req.last_step    = last;
    return req;
  endfunction

  task automatic write_reg(logic [CfgIndexBits-1:0] idx, logic [DataWidth-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      RegDriftDt, RegVolvolRho: coef[idx] = longint'($signed(data));
      default: coef[idx] = longint'({1'b0, data[DataWidth-2:0]});
    endcase
  endtask

  task automatic apply_set(cfg_set_e set);
    logic [DataWidth-1:0] vals [8];
    case (set)
      CfgKeep: return;
      CfgCalm: begin
        // dt = 1/64, mu = 0.05, kappa = 2, theta = 0.04, sigma = 0.5, rho = -0.7
        vals[RegDriftDt]          = 32'd13107;
        vals[RegHalfDt]           = 32'd131072;
        vals[RegReversionDt]      = 32'd524288;
        vals[RegReversionLevelDt] = 32'd20972;
        vals[RegRootDt]           = 32'd2097152;
        vals[RegVolvolRho]        = -32'sd734003;
        vals[RegVolvolRhoComp]    = 32'd748820;
        vals[RegInitialVariance]  = 32'd671089;
      end
      CfgWild: begin
        // dt = 1/16, sigma = 3: far outside the Feller bound
        vals[RegDriftDt]          = 32'd104858;
        vals[RegHalfDt]           = 32'd524288;
        vals[RegReversionDt]      = 32'd1048576;
        vals[RegReversionLevelDt] = 32'd94372;
        vals[RegRootDt]           = 32'd4194304;
        vals[RegVolvolRho]        = 32'd3774874;
        vals[RegVolvolRhoComp]    = 32'd12003140;
        vals[RegInitialVariance]  = 32'd1509949;
      end
      CfgTop: foreach (vals[r]) vals[r] = QMaxW;
      // top bit only: most negative signed, zero once the unsigned ones drop it
      CfgBottom: foreach (vals[r]) vals[r] = QMinW;
      default: foreach (vals[r]) vals[r] = $urandom;
    endcase
    foreach (vals[r]) write_reg(CfgIndexBits'(r), vals[r]);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_points.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic offer_step(svps_in_t req, logic typed, svps_out_t want);
    svps_out_t pt;
    int        gap;
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    pt = advance_path(req);
    expected_points.push_back(typed ? want : pt);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 120);
      burst_left = $urandom_range(0, 10);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Receiver: stall modes of random length, plus long hold-offs on request
  initial begin : out_stall_gen
    int mode;
    int mode_left;
    int hold_seen;
    mode        = 0;
    mode_left   = 0;
    hold_seen   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_seen != hold_seq) begin
        hold_seen = hold_seq;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 300);
        end
        mode_left--;
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          2: out_stall_i <= ($urandom_range(0, 9) < 7);
          default: out_stall_i <= ~out_stall_i;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : check_points
    svps_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected result, log_offset %0d variance %0d", $time,
                 out_data_o.log_offset, out_data_o.variance_out);
        mismatches++;
      end else begin
        want = expected_points.pop_front();
        if (out_data_o.log_offset !== want.log_offset) begin
          $display("%0t: log_offset expected %0d got %0d", $time,
                   want.log_offset, out_data_o.log_offset);
          mismatches++;
        end
        if (out_data_o.variance_out !== want.variance_out) begin
          $display("%0t: variance_out expected %0d got %0d", $time,
                   want.variance_out, out_data_o.variance_out);
          mismatches++;
        end
        if (out_data_o.path_end !== want.path_end) begin
          $display("%0t: path_end expected %0b got %0b", $time,
                   want.path_end, out_data_o.path_end);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no handshake for %0d cycles", $time, WatchdogLimit);
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    cfg_set_e  phase_sets [9];
    cfg_set_e  active_set;
    step_row_t row;
    svps_in_t  req;
    svps_out_t want;
    int        sent;
    int        len;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    in_data_i       = '0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = '0;
    cfg_data_i      = '0;
    mismatches      = 0;
    burst_left      = 0;
    hold_seq        = 0;
    path_variance   = 0;
    path_log_offset = 0;
    foreach (coef[r]) coef[r] = 0;
    phase_sets = '{CfgCalm, CfgWild, CfgRandom, CfgTop, CfgCalm,
                   CfgBottom, CfgRandom, CfgWild, CfgCalm};
    active_set = CfgKeep;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DirectedRows[i]) begin
      row = DirectedRows[i];
      if (row.set != CfgKeep && row.set != active_set) begin
        drain_results();
        apply_set(row.set);
        active_set = row.set;
      end
      req  = '{row.z_price, row.z_indep, row.start, row.last};
      want = '{row.want_log, row.want_var, row.last};
      offer_step(req, row.typed, want);
    end

    foreach (phase_sets[p]) begin
      drain_results();
      apply_set(phase_sets[p]);
      if (p == 4) begin
        // output held off while requests keep coming
        hold_seq++;
        burst_left = 12;
      end
      sent = 0;
      while (sent < PhaseItems) begin
        if (p == 1 && sent >= 30 && sent < 33) drain_results();
        if ($urandom_range(0, 99) < 15) begin
          offer_step(make_step($urandom_range(0, 1), $urandom_range(0, 1)), 1'b0, want);
          sent++;
        end else begin
          len = $urandom_range(1, 12);
          for (int k = 0; k < len; k++) begin
            offer_step(make_step(k == 0, k == len - 1), 1'b0, want);
            sent++;
          end
        end
      end
    end

    drain_results();
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

### sim.f
rtl/svps_pkg.sv
rtl/svps_sqrt.sv
rtl/svps_alu.sv
rtl/stochastic_volatility_path_step_unit.sv
rtl/svps_checker.sv
sim/stochastic_volatility_path_step_unit_test.sv
